/* rtl/core/csb_pkg.sv */
// csb_pkg: shared types and constants for the clipped transparent sprite blit.
// Register indexes, field widths, reset values and the dimension clamp function.
// No dependencies.
package csb_pkg;

  localparam int unsigned REG_W       = 10;  // geometry register width
  localparam int unsigned ADDR_W      = 18;  // destination write address width
  localparam int unsigned IDX_W       = 3;   // register index width
  localparam int unsigned QUEUE_DEPTH = 4;   // front-to-back queue entries

  typedef enum logic [IDX_W-1:0] {
    REG_SRC_WIDTH   = 3'd0,
    REG_SRC_HEIGHT  = 3'd1,
    REG_DST_WIDTH   = 3'd2,
    REG_DST_HEIGHT  = 3'd3,
    REG_X_ORIGIN    = 3'd4,
    REG_Y_ORIGIN    = 3'd5,
    REG_TRANSPARENT = 3'd6
  } csb_reg_t;

  localparam logic [REG_W-1:0] SRC_WIDTH_RST  = 10'd16;
  localparam logic [REG_W-1:0] SRC_HEIGHT_RST = 10'd16;
  localparam logic [REG_W-1:0] DST_WIDTH_RST  = 10'd240;
  localparam logic [REG_W-1:0] DST_HEIGHT_RST = 10'd320;
  localparam logic [REG_W-1:0] OFFSET_RST     = 10'd0;

  // Geometry as seen by the datapath: dimensions already clamped.
  typedef struct packed {
    logic [REG_W-1:0] src_w;
    logic [REG_W-1:0] src_h;
    logic [REG_W-1:0] dst_w;
    logic [REG_W-1:0] dst_h;
    logic [REG_W-1:0] x_off;  // two's complement
    logic [REG_W-1:0] y_off;  // two's complement
  } csb_geom_t;

  // Zero reads as one, anything above max_dim reads as max_dim.
  function automatic logic [REG_W-1:0] eff_dim(input logic [REG_W-1:0] v,
                                               input int unsigned max_dim);
    logic [REG_W-1:0] r;
    if (v == '0) begin
      r = REG_W'(1);
    end else if (32'(v) > max_dim) begin
      r = REG_W'(max_dim);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

/* rtl/core/csb_queue.sv */
// csb_queue: small register queue between the classify front and the address back.
// Depends on csb_pkg for its depth.
module csb_queue #(
  parameter int unsigned WIDTH = 36
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  output logic             pop_valid,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data
);

  localparam int unsigned DEPTH = csb_pkg::QUEUE_DEPTH;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_W'(DEPTH));
  assign pop_valid = (count != '0);
  assign pop_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full && !pop))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && !pop_valid))
    else $error("pop from empty queue");

endmodule

/* rtl/core/csb_front.sv */
// csb_front: accepts source pixels, tracks sprite column/row, clips and color-keys.
// Kept pixels go to the queue as destination (row, column, pixel). Depends on csb_pkg.
module csb_front #(
  parameter int unsigned MAX_DIM    = 512,
  parameter int unsigned PIXEL_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  csb_pkg::csb_geom_t       geom,
  input  logic [PIXEL_BITS-1:0]    key,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [PIXEL_BITS-1:0]    pixel,
  input  logic                     first,
  input  logic                     queue_full,
  output logic                     push,
  output logic [2*csb_pkg::REG_W+PIXEL_BITS-1:0] push_data
);

  localparam int unsigned REG_W = csb_pkg::REG_W;
  localparam int unsigned CNT_W = $clog2(MAX_DIM);
  // compare width: holds counter+1 and any dimension
  localparam int unsigned CW    = (CNT_W + 1 > REG_W) ? CNT_W + 1 : REG_W;
  localparam int unsigned SX_W  = CW + 1;

  logic [CNT_W-1:0]       col;
  logic [CNT_W-1:0]       row;
  logic [CNT_W-1:0]       col_next;
  logic [CNT_W-1:0]       row_next;
  logic [CNT_W-1:0]       col_cur;
  logic [CNT_W-1:0]       row_cur;
  logic [CW-1:0]          col_inc;
  logic [CW-1:0]          row_inc;
  logic signed [SX_W-1:0] dx;
  logic signed [SX_W-1:0] dy;
  logic                   in_x;
  logic                   in_y;
  logic                   in_sprite;
  logic                   keep;
  logic                   accept;

  assign in_ready = !queue_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    col_cur = first ? '0 : col;
    row_cur = first ? '0 : row;

    dx = SX_W'($signed(geom.x_off)) + $signed({1'b0, CW'(col_cur)});
    dy = SX_W'($signed(geom.y_off)) + $signed({1'b0, CW'(row_cur)});

    in_x = !dx[SX_W-1] && (dx[CW-1:0] < CW'(geom.dst_w));
    in_y = !dy[SX_W-1] && (dy[CW-1:0] < CW'(geom.dst_h));
    in_sprite = (CW'(col_cur) < CW'(geom.src_w)) && (CW'(row_cur) < CW'(geom.src_h));
    keep = in_sprite && in_x && in_y && (pixel != key);

    // raster advance, wrapping at the sprite edges
    col_inc = CW'(col_cur) + 1'b1;
    row_inc = CW'(row_cur) + 1'b1;
    if (col_inc >= CW'(geom.src_w)) begin
      col_next = '0;
      row_next = (row_inc >= CW'(geom.src_h)) ? '0 : row_inc[CNT_W-1:0];
    end else begin
      col_next = col_inc[CNT_W-1:0];
      row_next = row_cur;
    end
  end

  // in-range positions are below dst_w / dst_h, so REG_W bits hold them
  assign push      = accept && keep;
  assign push_data = {pixel, dx[REG_W-1:0], dy[REG_W-1:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      col <= col_next;
      row <= row_next;
    end
  end

  a_first_restart: assert property (@(posedge clk) disable iff (rst)
    (accept && first) |=> (row == '0 || row == CNT_W'(1)))
    else $error("row not restarted by first-of-sprite");

endmodule

/* rtl/core/csb_back.sv */
// csb_back: turns queued (row, column, pixel) into destination writes.
// Stage 1 multiplies row by pitch, stage 2 adds column into the output register. Depends on csb_pkg.
module csb_back #(
  parameter int unsigned PIXEL_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [csb_pkg::REG_W-1:0] dst_w,
  input  logic                     q_valid,
  output logic                     q_pop,
  input  logic [2*csb_pkg::REG_W+PIXEL_BITS-1:0] q_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [csb_pkg::ADDR_W-1:0] out_addr,
  output logic [PIXEL_BITS-1:0]    out_pixel
);

  localparam int unsigned REG_W  = csb_pkg::REG_W;
  localparam int unsigned ADDR_W = csb_pkg::ADDR_W;
  localparam int unsigned PROD_W = 2 * REG_W;

  logic [REG_W-1:0]      q_dy;
  logic [REG_W-1:0]      q_dx;
  logic [PIXEL_BITS-1:0] q_pix;
  logic                  s1_valid;
  logic [PROD_W-1:0]     s1_prod;
  logic [REG_W-1:0]      s1_dx;
  logic [PIXEL_BITS-1:0] s1_pix;
  logic [PROD_W-1:0]     sum;
  logic                  out_adv;
  logic                  s1_adv;

  assign {q_pix, q_dx, q_dy} = q_data;

  assign out_adv = !out_valid || out_ready;
  assign s1_adv  = !s1_valid || out_adv;
  assign q_pop   = q_valid && s1_adv;
  assign sum     = s1_prod + PROD_W'(s1_dx);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_adv) begin
        s1_valid <= q_valid;
      end
      if (out_adv) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_prod <= q_dy * dst_w;
      s1_dx   <= q_dx;
      s1_pix  <= q_pix;
    end
    if (out_adv && s1_valid) begin
      out_addr  <= sum[ADDR_W-1:0];
      out_pixel <= s1_pix;
    end
  end

  a_out_from_s1: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s1_valid))
    else $error("output valid without a stage 1 item");

endmodule

/* rtl/core/clipped_transparent_sprite_blit.sv */
// Clipped, color-keyed sprite blit: one source pixel per transaction in, zero or one write out.
// Throughput: one pixel per clock; a kept pixel passes the queue, back stage 1 and the output register to m_tdata.
// The front stalls only when the 4-entry queue is full; the back stalls only on m_tready.
// Reset (rst, synchronous, active high) restores default geometry and color key, clears counters and queue.
// Depends on csb_pkg, csb_front, csb_queue, csb_back.
module clipped_transparent_sprite_blit #(
  parameter int unsigned MAX_DIM    = 512,
  parameter int unsigned PIXEL_BITS = 16
) (
  input  logic clk,
  input  logic rst,

  // configuration write port
  input  logic                            cfg_we,
  input  logic [csb_pkg::IDX_W-1:0]       cfg_addr,
  input  logic [((PIXEL_BITS > csb_pkg::REG_W) ? PIXEL_BITS : csb_pkg::REG_W)-1:0] cfg_data,

  // source pixel stream
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [((PIXEL_BITS + 7) / 8) * 8 - 1:0] s_tdata,  // src_pixel
  input  logic                            s_tuser,          // first_of_sprite

  // destination write stream
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // write_address [17:0], write_pixel above it, zero padded to whole bytes
  output logic [((csb_pkg::ADDR_W + PIXEL_BITS + 7) / 8) * 8 - 1:0] m_tdata
);

  localparam int unsigned REG_W  = csb_pkg::REG_W;
  localparam int unsigned ADDR_W = csb_pkg::ADDR_W;
  localparam int unsigned OUT_W  = ((ADDR_W + PIXEL_BITS + 7) / 8) * 8;
  localparam int unsigned Q_W    = 2 * REG_W + PIXEL_BITS;

  // raw configuration registers
  logic [REG_W-1:0]      src_width;
  logic [REG_W-1:0]      src_height;
  logic [REG_W-1:0]      dst_width;
  logic [REG_W-1:0]      dst_height;
  logic [REG_W-1:0]      x_origin;
  logic [REG_W-1:0]      y_origin;
  logic [PIXEL_BITS-1:0] transparent_color;

  csb_pkg::csb_geom_t    geom;

  logic                  push;
  logic [Q_W-1:0]        push_data;
  logic                  queue_full;
  logic                  q_valid;
  logic                  q_pop;
  logic [Q_W-1:0]        q_data;
  logic [ADDR_W-1:0]     out_addr;
  logic [PIXEL_BITS-1:0] out_pixel;

  // Config writes land immediately; the user must issue them only while the block is idle,
  // so no in-flight pixel sees a half-updated geometry. The block does not enforce this.
  always_ff @(posedge clk) begin
    if (rst) begin
      src_width         <= csb_pkg::SRC_WIDTH_RST;
      src_height        <= csb_pkg::SRC_HEIGHT_RST;
      dst_width         <= csb_pkg::DST_WIDTH_RST;
      dst_height        <= csb_pkg::DST_HEIGHT_RST;
      x_origin          <= csb_pkg::OFFSET_RST;
      y_origin          <= csb_pkg::OFFSET_RST;
      transparent_color <= {PIXEL_BITS{1'b1}};
    end else if (cfg_we) begin
      case (csb_pkg::csb_reg_t'(cfg_addr))
        csb_pkg::REG_SRC_WIDTH:   src_width         <= cfg_data[REG_W-1:0];
        csb_pkg::REG_SRC_HEIGHT:  src_height        <= cfg_data[REG_W-1:0];
        csb_pkg::REG_DST_WIDTH:   dst_width         <= cfg_data[REG_W-1:0];
        csb_pkg::REG_DST_HEIGHT:  dst_height        <= cfg_data[REG_W-1:0];
        csb_pkg::REG_X_ORIGIN:    x_origin          <= cfg_data[REG_W-1:0];
        csb_pkg::REG_Y_ORIGIN:    y_origin          <= cfg_data[REG_W-1:0];
        csb_pkg::REG_TRANSPARENT: transparent_color <= cfg_data[PIXEL_BITS-1:0];
        default: ;  // unmapped index: ignored
      endcase
    end
  end

  // Clamp dimensions once here; front and back see only legal sizes.
  always_comb begin
    geom.src_w = csb_pkg::eff_dim(src_width,  MAX_DIM);
    geom.src_h = csb_pkg::eff_dim(src_height, MAX_DIM);
    geom.dst_w = csb_pkg::eff_dim(dst_width,  MAX_DIM);
    geom.dst_h = csb_pkg::eff_dim(dst_height, MAX_DIM);
    geom.x_off = x_origin;
    geom.y_off = y_origin;
  end

  // Front: counters, clip window, color key. Dropped pixels never enter the queue.
  csb_front #(
    .MAX_DIM    (MAX_DIM),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .geom       (geom),
    .key        (transparent_color),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .pixel      (s_tdata[PIXEL_BITS-1:0]),
    .first      (s_tuser),
    .queue_full (queue_full),
    .push       (push),
    .push_data  (push_data)
  );

  // Decouples the front, one pixel per clock while the queue is not full, from output back-pressure.
  csb_queue #(
    .WIDTH (Q_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (queue_full),
    .pop_valid (q_valid),
    .pop       (q_pop),
    .pop_data  (q_data)
  );

  // Back: row * pitch, then + column, into the output register.
  csb_back #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .dst_w     (geom.dst_w),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_data    (q_data),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_addr  (out_addr),
    .out_pixel (out_pixel)
  );

  assign m_tdata = OUT_W'({out_pixel, out_addr});

endmodule

/* tb/clipped_transparent_sprite_blit_test.sv */
`timescale 1ns / 1ps
// Self-checking testbench for clipped_transparent_sprite_blit: directed corner sprites, then random
// sprite phases, each write checked against an in-bench predictor of the blit.
// Depends on csb_pkg and the clipped_transparent_sprite_blit RTL.
module clipped_transparent_sprite_blit_test;

  localparam int ADDR_W       = csb_pkg::ADDR_W;
  localparam int REG_W        = csb_pkg::REG_W;
  localparam int IDX_W        = csb_pkg::IDX_W;
  localparam int PIX_W        = 16;
  localparam int CFG_W        = 16;
  localparam int OUT_W        = ((ADDR_W + PIX_W + 7) / 8) * 8;
  localparam int MAX_SIZE     = 512;
  localparam int DRAIN_CYCLES = 8;       // margin for items still in flight
  localparam int LIMIT_CYCLES = 200000;
  localparam int TARGET_ITEMS = 950;
  localparam logic [IDX_W-1:0] REG_UNUSED    = 3'd7;  // index with no register behind it
  localparam logic [PIX_W-1:0] KEY_COLOR_RST = 16'hFFFF;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [PIX_W-1:0]  pixel;
  } dst_write_t;

  logic             clk;
  logic             rst      = 1'b1;
  logic             cfg_we   = 1'b0;
  logic [IDX_W-1:0] cfg_addr = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [PIX_W-1:0] s_tdata  = '0;   // src_pixel
  logic             s_tuser  = 1'b0; // first_of_sprite
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;         // write_address, write_pixel, zero padding

  // Shadow copy of the register file, as the block should hold it.
  logic [REG_W-1:0] src_w_reg     = csb_pkg::SRC_WIDTH_RST;
  logic [REG_W-1:0] src_h_reg     = csb_pkg::SRC_HEIGHT_RST;
  logic [REG_W-1:0] dst_w_reg     = csb_pkg::DST_WIDTH_RST;
  logic [REG_W-1:0] dst_h_reg     = csb_pkg::DST_HEIGHT_RST;
  logic [REG_W-1:0] x_off_reg     = csb_pkg::OFFSET_RST;
  logic [REG_W-1:0] y_off_reg     = csb_pkg::OFFSET_RST;
  logic [PIX_W-1:0] key_color_reg = KEY_COLOR_RST;

  // Position of the next source pixel inside the sprite.
  logic [8:0] sprite_col = '0;
  logic [8:0] sprite_row = '0;

  dst_write_t pending_writes[$];  // predicted writes, oldest first
  dst_write_t oldest_write;
  int         mismatch_count = 0;
  int         pixels_sent    = 0;
  int         cycle_count    = 0;
  bit         full_rate      = 1'b0;  // both sides stop idling while set

  clipped_transparent_sprite_blit i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Size registers: zero acts as one, anything past the maximum acts as the maximum.
  function automatic int eff_size(input logic [REG_W-1:0] v);
    int n;
    n = int'(v);
    if (n == 0) n = 1;
    else if (n > MAX_SIZE) n = MAX_SIZE;
    return n;
  endfunction

  // Place one accepted source pixel and queue the destination write it should cause.
  function automatic void place_pixel(input logic [PIX_W-1:0] pix, input logic first);
    int sw, sh, dw, dh, dx, dy;
    dst_write_t w;
    sw = eff_size(src_w_reg);
    sh = eff_size(src_h_reg);
    dw = eff_size(dst_w_reg);
    dh = eff_size(dst_h_reg);
    if (first) begin
      sprite_col = '0;
      sprite_row = '0;
    end
    dx = int'($signed(x_off_reg)) + int'(sprite_col);
    dy = int'($signed(y_off_reg)) + int'(sprite_row);
    // Counters can sit past a sprite that shrank mid-run: those pixels are dropped too.
    if (int'(sprite_col) < sw && int'(sprite_row) < sh && dx >= 0 && dx < dw &&
        dy >= 0 && dy < dh && pix != key_color_reg) begin
      w.addr  = ADDR_W'(dy * dw + dx);
      w.pixel = pix;
      pending_writes.push_back(w);
    end
    // Raster advance; the end of the last row wraps back to the top-left corner.
    if (int'(sprite_col) + 1 >= sw) begin
      sprite_col = '0;
      if (int'(sprite_row) + 1 >= sh) sprite_row = '0;
      else sprite_row = sprite_row + 9'd1;
    end else begin
      sprite_col = sprite_col + 9'd1;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver, checker and watchdog
  // ---------------------------------------------------------------------------

  // Destination side backs off at random about 8 percent of the time, never while full_rate is set.
  always @(posedge clk) begin
    m_tready <= full_rate || ($urandom_range(99) >= 8);
  end

  // Every write transaction is compared against the oldest predicted write.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_writes.size() == 0) begin
        $display("%0t ERROR: unexpected write, expected none, actual addr %h pixel %h",
                 $time, m_tdata[ADDR_W-1:0], m_tdata[ADDR_W+PIX_W-1:ADDR_W]);
        mismatch_count++;
      end else begin
        oldest_write = pending_writes.pop_front();
        if (m_tdata[ADDR_W-1:0] !== oldest_write.addr) begin
          $display("%0t ERROR: write_address expected %h actual %h",
                   $time, oldest_write.addr, m_tdata[ADDR_W-1:0]);
          mismatch_count++;
        end
        if (m_tdata[ADDR_W+PIX_W-1:ADDR_W] !== oldest_write.pixel) begin
          $display("%0t ERROR: write_pixel expected %h actual %h",
                   $time, oldest_write.pixel, m_tdata[ADDR_W+PIX_W-1:ADDR_W]);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // One source pixel transaction. Valid stays high into the next call unless a gap is drawn,
  // so it is never lowered and raised in the same step.
  task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic first);
    int gap;
    gap = 0;
    if (!full_rate && $urandom_range(99) < 3) gap = $urandom_range(1, 4);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= pix;
    s_tuser  <= first;
    do @(posedge clk); while (!s_tready);
    place_pixel(pix, first);
    pixels_sent++;
  endtask

  // Stop the source and wait for every predicted write, then for anything still in flight
  // that causes no write.
  task automatic drain_writes();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_writes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Leaves cfg_we high; the caller lowers it once the burst of writes is done.
  task automatic set_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      csb_pkg::REG_SRC_WIDTH:   src_w_reg     = data[REG_W-1:0];
      csb_pkg::REG_SRC_HEIGHT:  src_h_reg     = data[REG_W-1:0];
      csb_pkg::REG_DST_WIDTH:   dst_w_reg     = data[REG_W-1:0];
      csb_pkg::REG_DST_HEIGHT:  dst_h_reg     = data[REG_W-1:0];
      csb_pkg::REG_X_ORIGIN:    x_off_reg     = data[REG_W-1:0];
      csb_pkg::REG_Y_ORIGIN:    y_off_reg     = data[REG_W-1:0];
      csb_pkg::REG_TRANSPARENT: key_color_reg = data;
      default: ;
    endcase
  endtask

  task automatic apply_config(input logic [CFG_W-1:0] sw, input logic [CFG_W-1:0] sh,
                              input logic [CFG_W-1:0] dw, input logic [CFG_W-1:0] dh,
                              input logic [CFG_W-1:0] xo, input logic [CFG_W-1:0] yo,
                              input logic [CFG_W-1:0] key);
    set_reg(csb_pkg::REG_SRC_WIDTH, sw);
    set_reg(csb_pkg::REG_SRC_HEIGHT, sh);
    set_reg(csb_pkg::REG_DST_WIDTH, dw);
    set_reg(csb_pkg::REG_DST_HEIGHT, dh);
    set_reg(csb_pkg::REG_X_ORIGIN, xo);
    set_reg(csb_pkg::REG_Y_ORIGIN, yo);
    set_reg(csb_pkg::REG_TRANSPARENT, key);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Unused upper bits of a geometry write get random junk now and then; only 10 bits count.
  function automatic logic [CFG_W-1:0] junk_upper(input logic [REG_W-1:0] v);
    logic [CFG_W-1:0] r;
    r = {6'b0, v};
    if ($urandom_range(99) < 10) r[CFG_W-1:REG_W] = 6'($urandom_range(63));
    return r;
  endfunction

  // Mostly small sizes, with the clamp cases and the maximum mixed in.
  function automatic logic [CFG_W-1:0] pick_dim(input int small_max);
    int r;
    logic [REG_W-1:0] v;
    r = $urandom_range(99);
    if (r < 70) v = REG_W'($urandom_range(1, small_max));
    else if (r < 76) v = '0;
    else if (r < 84) v = REG_W'(MAX_SIZE);
    else if (r < 90) v = '1;
    else v = REG_W'($urandom_range(1023));
    return junk_upper(v);
  endfunction

  // Offset near the frame so the sprite straddles an edge, or anywhere at all.
  function automatic logic [CFG_W-1:0] pick_offset(input int sprite, input int frame);
    int v;
    if ($urandom_range(99) < 80) v = int'($urandom_range(frame + sprite + 2)) - (sprite + 1);
    else v = int'($urandom_range(1023));
    return junk_upper(v[REG_W-1:0]);
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset geometry: 16x16 sprite at the origin of a 240x320 frame, key 0xFFFF.
  task automatic test_reset_defaults();
    send_pixel(16'h0000, 1'b1);
    send_pixel(16'hFFFF, 1'b0);  // keyed out
    send_pixel(16'h8001, 1'b0);
    send_pixel(16'h7FFE, 1'b0);
    drain_writes();
  endtask

  task automatic test_extremes();
    // Zero sizes act as 1x1, oversize frame acts as 512: every pixel that lands hits the top address.
    apply_config(16'd0, 16'd0, 16'd1023, 16'd1023, 16'd511, 16'd511, 16'h0000);
    send_pixel(16'hFFFF, 1'b0);
    send_pixel(16'h0000, 1'b0);  // keyed out
    send_pixel(16'hA5A5, 1'b1);
    drain_writes();

    // Offsets of -512 and -511 push the whole sprite off the frame.
    apply_config(16'd4, 16'd2, 16'd512, 16'd512, 16'h0200, 16'h0201, 16'h1234);
    send_pixel(16'h4321, 1'b1);
    send_pixel(16'h1234, 1'b0);
    drain_writes();

    // 1x1 frame, 3x2 sprite at (-2,-1): only its last pixel lands. The sprite wraps at its
    // end, so the stream repeats it without a new first flag. Junk sits in the upper bits.
    apply_config(16'hFC03, 16'h0402, 16'd1, 16'd1, 16'h03FE, 16'hFFFF, 16'h5555);
    send_pixel(16'h1111, 1'b1);
    send_pixel(16'h2222, 1'b0);
    send_pixel(16'h3333, 1'b0);
    send_pixel(16'h4444, 1'b0);
    send_pixel(16'h5555, 1'b0);
    send_pixel(16'h6666, 1'b0);
    send_pixel(16'h7777, 1'b0);
    send_pixel(16'h8888, 1'b0);
    drain_writes();

    // Width shrinks while the column counter is already past the new width.
    apply_config(16'd8, 16'd8, 16'd64, 16'd64, 16'd0, 16'd0, 16'hFFFF);
    send_pixel(16'h0101, 1'b1);
    send_pixel(16'h0202, 1'b0);
    send_pixel(16'h0303, 1'b0);
    send_pixel(16'h0404, 1'b0);
    send_pixel(16'h0505, 1'b0);
    drain_writes();
    apply_config(16'd3, 16'd8, 16'd64, 16'd64, 16'd0, 16'd0, 16'hFFFF);
    send_pixel(16'h0606, 1'b0);  // column 5 of a 3-wide sprite: dropped
    send_pixel(16'h0707, 1'b0);
    send_pixel(16'h0808, 1'b0);
    drain_writes();

    // Height shrinks under the row counter; the unused index must change nothing.
    apply_config(16'd3, 16'd1, 16'd64, 16'd64, 16'd0, 16'd0, 16'hFFFF);
    set_reg(REG_UNUSED, 16'hFFFF);
    cfg_we <= 1'b0;
    @(posedge clk);
    send_pixel(16'h0909, 1'b0);  // row 1 of a 1-high sprite: dropped
    send_pixel(16'h0A0A, 1'b0);
    drain_writes();
  endtask

  // One long stretch at full rate on both sides.
  task automatic test_back_to_back();
    logic [PIX_W-1:0] key;
    logic [PIX_W-1:0] pix;
    logic first;
    key = PIX_W'($urandom);
    apply_config(16'd7, 16'd5, 16'd20, 16'd12, 16'h03FD, 16'd9, key);
    full_rate = 1'b1;
    for (int i = 0; i < 160; i++) begin
      first = (i == 0) || ($urandom_range(99) < 4);
      pix = ($urandom_range(99) < 25) ? key : PIX_W'($urandom);
      send_pixel(pix, first);
    end
    full_rate = 1'b0;
    drain_writes();
  endtask

  // Random geometry per phase, mostly whole sprites with random content, some truncated,
  // repeated or sprinkled with stray first flags. Counters carry over between phases.
  task automatic test_random_sprites();
    logic [CFG_W-1:0] sw, sh, dw, dh, xo, yo;
    logic [PIX_W-1:0] key;
    logic [PIX_W-1:0] pix;
    logic first;
    int len;
    int sprites;
    while (pixels_sent < TARGET_ITEMS) begin
      sw = pick_dim(12);
      sh = pick_dim(12);
      dw = pick_dim(40);
      dh = pick_dim(40);
      xo = pick_offset(eff_size(sw[REG_W-1:0]), eff_size(dw[REG_W-1:0]));
      yo = pick_offset(eff_size(sh[REG_W-1:0]), eff_size(dh[REG_W-1:0]));
      key = PIX_W'($urandom);
      apply_config(sw, sh, dw, dh, xo, yo, key);
      sprites = $urandom_range(1, 4);
      for (int s = 0; s < sprites && pixels_sent < TARGET_ITEMS; s++) begin
        len = eff_size(sw[REG_W-1:0]) * eff_size(sh[REG_W-1:0]);
        if ($urandom_range(99) < 15) len += $urandom_range(1, len);      // repeat past the end
        else if ($urandom_range(99) < 10) len = $urandom_range(1, len);  // cut short
        if (len > 80) len = $urandom_range(20, 80);
        for (int i = 0; i < len; i++) begin
          first = (i == 0);
          if ($urandom_range(99) < 8) first = 1'($urandom_range(1));
          pix = ($urandom_range(99) < 25) ? key : PIX_W'($urandom);
          send_pixel(pix, first);
        end
      end
      drain_writes();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_extremes();
    test_back_to_back();
    test_random_sprites();
    drain_writes();
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/csb_pkg.sv
rtl/core/csb_queue.sv
rtl/core/csb_front.sv
rtl/core/csb_back.sv
rtl/core/clipped_transparent_sprite_blit.sv
tb/clipped_transparent_sprite_blit_test.sv
